FILE: hw/rtl/gaussian_peak_eval_assert.svh
// Assertion macros shared by the RTL of the Gaussian peak evaluator.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef GAUSSIAN_PEAK_EVAL_ASSERT_SVH
`define GAUSSIAN_PEAK_EVAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gpe_pkg.sv
`timescale 1ns / 1ps
package gpe_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int WIDTH_W   = 31;

    // Long divider: numerator of sign-extended difference or scaled product
    localparam int QUOT_W     = 32;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUOT_W / DIV_BITS;
    localparam int NUM_W      = DATA_W + 1 + FRAC_BITS;

    // |u| range: the exp term is zero from 8.0 on
    localparam int FAR_SHIFT = 3;
    localparam int A_W       = FRAC_BITS + FAR_SHIFT;

    // exp(-s) datapath in Q.30
    localparam int Q_FRAC    = 30;
    localparam int S_W       = 30;
    localparam int QV_W      = 31;
    localparam int EXP_TERMS = 14;
    localparam int SQUARINGS = 5;
    localparam int E_W       = FRAC_BITS + 1;

    // 1/sqrt(pi) in Q.30 and the split of the scale product
    localparam int K_W     = 30;
    localparam int SPLIT_W = 25;
    localparam int PL_W    = SPLIT_W + K_W;
    localparam int PH_W    = NUM_W - SPLIT_W + K_W;
    localparam int P_W     = NUM_W + K_W;

    typedef logic [DATA_W-1:0]  word_t;
    typedef logic [WIDTH_W-1:0] wid_t;
    typedef logic [WIDTH_W:0]   wid_step_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [A_W-1:0]     a_t;
    typedef logic [2*A_W-1:0]   asq_t;
    typedef logic [S_W-1:0]     s_t;
    typedef logic [QV_W-1:0]    qv_t;
    typedef logic [QV_W:0]      qvx_t;
    typedef logic [QV_W+1:0]    sum_t;
    typedef logic [QV_W+S_W-1:0] ts_t;
    typedef logic [QV_W+DATA_W-1:0] rp_t;
    typedef logic [2*QV_W-1:0]  qsq_t;
    typedef logic [E_W-1:0]     e_t;
    typedef logic [K_W-1:0]     k_t;
    typedef logic [PL_W-1:0]    pl_t;
    typedef logic [PH_W-1:0]    ph_t;
    typedef logic [P_W-1:0]     p_t;

    localparam k_t  INV_SQRT_PI = k_t'(605793952);
    localparam qv_t Q30_ONE     = qv_t'(1) << Q_FRAC;
    localparam qv_t Q30_HALF    = qv_t'(1) << (Q_FRAC - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_AMPLITUDE = cfg_idx_t'(0);
    localparam cfg_idx_t REG_CENTROID  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_WIDTH     = cfg_idx_t'(2);

    localparam word_t AMP_RESET   = word_t'(1) << FRAC_BITS;
    localparam word_t CENT_RESET  = '0;
    localparam wid_t  WIDTH_RESET = wid_t'(1) << FRAC_BITS;

    localparam word_t SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic tag;
        num_t num;
    } div_req_t;

    typedef struct packed {
        logic                valid;
        logic                tag;
        wid_t                rem;
        logic [QUOT_W-1:0]   low;
        logic [QUOT_W-1:0]   quot;
    } div_stage_t;

    typedef struct packed {
        logic valid;
        logic far;
        a_t   a;
    } exp_req_t;

    typedef struct packed {
        logic valid;
        logic far;
        s_t   s;
        sum_t sum;
        qv_t  term;
        qv_t  v;
    } exp_stage_t;

    typedef struct packed {
        logic valid;
        logic far;
        qv_t  e;
    } sq_stage_t;

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic wid_step_t div_step(input wid_t rem, input logic nb, input wid_t dvs);
        wid_step_t trial;
        wid_step_t diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs})
            return {1'b1, diff[WIDTH_W-1:0]};
        else
            return {1'b0, trial[WIDTH_W-1:0]};
    endfunction

endpackage

FILE: hw/rtl/gpe_if.sv
`timescale 1ns / 1ps
interface gpe_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [gpe_pkg::DATA_W-1:0]   sample_pos;

    modport source (output valid, output sample_pos, input ready);
    modport sink (input valid, input sample_pos, output ready);
endinterface

interface gpe_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [gpe_pkg::DATA_W-1:0]   value;
    logic                                saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink (input valid, input value, input saturated, output ready);
endinterface

FILE: hw/rtl/gpe_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// The caller guarantees num / divisor < 2^QUOT_W unless tag marks the item.
module gpe_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  gpe_pkg::div_req_t   req,
    input  gpe_pkg::wid_t       divisor,
    output gpe_pkg::div_stage_t rsp
);

    gpe_pkg::div_stage_t stage_reg  [gpe_pkg::DIV_STAGES];
    gpe_pkg::div_stage_t stage_next [gpe_pkg::DIV_STAGES];
    gpe_pkg::div_stage_t head;

    always_comb
    begin
        head.valid = req.valid;
        head.tag   = req.tag;
        head.rem   = gpe_pkg::wid_t'(req.num[gpe_pkg::NUM_W-1:gpe_pkg::QUOT_W]);
        head.low   = req.num[gpe_pkg::QUOT_W-1:0];
        head.quot  = '0;
    end

    for (genvar k = 0; k < gpe_pkg::DIV_STAGES; k++)
    begin : g_stage
        gpe_pkg::div_stage_t src;

        if (k == 0)
        begin : g_first
            assign src = head;
        end
        else
        begin : g_rest
            assign src = stage_reg[k-1];
        end

        always_comb
        begin
            gpe_pkg::div_stage_t cur;
            gpe_pkg::wid_step_t  step;
            cur = src;
            for (int b = 0; b < gpe_pkg::DIV_BITS; b++)
            begin
                step     = gpe_pkg::div_step(cur.rem, cur.low[gpe_pkg::QUOT_W-1], divisor);
                cur.rem  = step[gpe_pkg::WIDTH_W-1:0];
                cur.quot = {cur.quot[gpe_pkg::QUOT_W-2:0], step[gpe_pkg::WIDTH_W]};
                cur.low  = {cur.low[gpe_pkg::QUOT_W-2:0], 1'b0};
            end
            stage_next[k] = cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_reg[k] <= '0;
            else if (en)
                stage_reg[k] <= stage_next[k];
        end
    end

    assign rsp = stage_reg[gpe_pkg::DIV_STAGES-1];

endmodule

FILE: hw/rtl/gpe_exp.sv
`timescale 1ns / 1ps
// exp(-u^2/2) in Q.30: square |u|, take exp(-u^2/64) by Taylor series,
// then square the result five times.
module gpe_exp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  gpe_pkg::exp_req_t  req,
    output gpe_pkg::sq_stage_t rsp
);

    gpe_pkg::exp_stage_t init_reg;
    gpe_pkg::exp_stage_t init_next;
    gpe_pkg::exp_stage_t mul_reg  [gpe_pkg::EXP_TERMS];
    gpe_pkg::exp_stage_t mul_next [gpe_pkg::EXP_TERMS];
    gpe_pkg::exp_stage_t rcp_reg  [gpe_pkg::EXP_TERMS];
    gpe_pkg::exp_stage_t rcp_next [gpe_pkg::EXP_TERMS];
    gpe_pkg::exp_stage_t fix_reg  [gpe_pkg::EXP_TERMS];
    gpe_pkg::exp_stage_t fix_next [gpe_pkg::EXP_TERMS];
    gpe_pkg::sq_stage_t  clamp_reg;
    gpe_pkg::sq_stage_t  clamp_next;
    gpe_pkg::sq_stage_t  sq_reg  [gpe_pkg::SQUARINGS];
    gpe_pkg::sq_stage_t  sq_next [gpe_pkg::SQUARINGS];

    // s = floor(a^2 / 2^(F+1)) moved to Q.30 and divided by 32
    always_comb
    begin
        gpe_pkg::asq_t asq;
        asq             = gpe_pkg::asq_t'(req.a) * gpe_pkg::asq_t'(req.a);
        init_next.valid = req.valid;
        init_next.far   = req.far;
        init_next.s     = gpe_pkg::s_t'((asq >> (gpe_pkg::FRAC_BITS + 1))
                                        << (25 - gpe_pkg::FRAC_BITS));
        init_next.sum   = gpe_pkg::sum_t'(gpe_pkg::Q30_ONE);
        init_next.term  = gpe_pkg::Q30_ONE;
        init_next.v     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_reg <= '0;
        else if (en)
            init_reg <= init_next;
    end

    for (genvar g = 0; g < gpe_pkg::EXP_TERMS; g++)
    begin : g_term
        localparam int N = g + 1;
        localparam logic [gpe_pkg::DATA_W-1:0] RECIP =
            gpe_pkg::DATA_W'(64'hFFFF_FFFF / 64'(N));
        gpe_pkg::exp_stage_t src;

        if (g == 0)
        begin : g_first
            assign src = init_reg;
        end
        else
        begin : g_rest
            assign src = fix_reg[g-1];
        end

        // term * s, back to Q.30
        always_comb
        begin
            gpe_pkg::ts_t p;
            p            = gpe_pkg::ts_t'(src.term) * gpe_pkg::ts_t'(src.s);
            mul_next[g]  = src;
            mul_next[g].v = p[gpe_pkg::Q_FRAC+gpe_pkg::QV_W-1:gpe_pkg::Q_FRAC];
        end

        // estimate v / N by reciprocal, low by at most one
        always_comb
        begin
            gpe_pkg::rp_t rp;
            rp               = gpe_pkg::rp_t'(mul_reg[g].v) * gpe_pkg::rp_t'(RECIP);
            rcp_next[g]      = mul_reg[g];
            rcp_next[g].term = rp[gpe_pkg::DATA_W+gpe_pkg::QV_W-1:gpe_pkg::DATA_W];
        end

        // correct the estimate and accumulate with alternating sign
        always_comb
        begin
            gpe_pkg::qvx_t qn;
            gpe_pkg::qvx_t rr;
            gpe_pkg::qv_t  q;
            qn = gpe_pkg::qvx_t'(rcp_reg[g].term) * gpe_pkg::qvx_t'(N);
            rr = gpe_pkg::qvx_t'(rcp_reg[g].v) - qn;
            q  = rcp_reg[g].term + gpe_pkg::qv_t'(rr >= gpe_pkg::qvx_t'(N));
            fix_next[g]      = rcp_reg[g];
            fix_next[g].term = q;
            if ((N % 2) == 1)
                fix_next[g].sum = rcp_reg[g].sum - gpe_pkg::sum_t'(q);
            else
                fix_next[g].sum = rcp_reg[g].sum + gpe_pkg::sum_t'(q);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mul_reg[g] <= '0;
                rcp_reg[g] <= '0;
                fix_reg[g] <= '0;
            end
            else if (en)
            begin
                mul_reg[g] <= mul_next[g];
                rcp_reg[g] <= rcp_next[g];
                fix_reg[g] <= fix_next[g];
            end
        end
    end

    // clamp the series to [0, 1.0]
    always_comb
    begin
        gpe_pkg::sum_t sum;
        sum              = fix_reg[gpe_pkg::EXP_TERMS-1].sum;
        clamp_next.valid = fix_reg[gpe_pkg::EXP_TERMS-1].valid;
        clamp_next.far   = fix_reg[gpe_pkg::EXP_TERMS-1].far;
        if (sum[gpe_pkg::QV_W+1])
            clamp_next.e = '0;
        else if (sum > gpe_pkg::sum_t'(gpe_pkg::Q30_ONE))
            clamp_next.e = gpe_pkg::Q30_ONE;
        else
            clamp_next.e = sum[gpe_pkg::QV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clamp_reg <= '0;
        else if (en)
            clamp_reg <= clamp_next;
    end

    for (genvar j = 0; j < gpe_pkg::SQUARINGS; j++)
    begin : g_square
        gpe_pkg::sq_stage_t src;

        if (j == 0)
        begin : g_first
            assign src = clamp_reg;
        end
        else
        begin : g_rest
            assign src = sq_reg[j-1];
        end

        always_comb
        begin
            gpe_pkg::qsq_t sq;
            sq = gpe_pkg::qsq_t'(src.e) * gpe_pkg::qsq_t'(src.e)
                 + gpe_pkg::qsq_t'(gpe_pkg::Q30_HALF);
            sq_next[j]   = src;
            sq_next[j].e = sq[gpe_pkg::Q_FRAC+gpe_pkg::QV_W-1:gpe_pkg::Q_FRAC];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_reg[j] <= '0;
            else if (en)
                sq_reg[j] <= sq_next[j];
        end
    end

    assign rsp = sq_reg[gpe_pkg::SQUARINGS-1];

endmodule

FILE: hw/rtl/gaussian_peak_eval.sv
`timescale 1ns / 1ps
// Gaussian peak evaluator: value = amplitude * exp(-u^2/2) / (width * sqrt(pi)),
// u = (sample_pos - centroid) / width, all signed Q16.16.
//
// samples: valid/ready channel carrying sample_pos; a transfer happens on a
//   rising edge with valid and ready both high.
// results: valid/ready channel carrying value and saturated, one result per
//   sample, in order.
// cfg_we/cfg_index/cfg_data: write amplitude (0), centroid (1), width (2) while
//   no sample is in flight; index 3 is ignored.
//
// A sample transfer reaches results through, in order: difference and range check,
// |u| divider, exp pipeline, amplitude scale, normalizing divider, output register.
// Throughput is one sample per cycle while the receiver takes results, as the
// datapath is fully pipelined.
// The whole pipeline advances as one: when a result is held back by the
// receiver, every stage holds and samples.ready drops until it is taken.
// Reset clears all valid bits and loads amplitude = 1.0, centroid = 0,
// width = 1.0. Width zero returns amplitude unchanged.
`include "gaussian_peak_eval_assert.svh"
module gaussian_peak_eval (
    input logic                      clk,
    input logic                      rst_n,
    gpe_sample_if.sink               samples,
    gpe_result_if.source             results,
    input logic                      cfg_we,
    input gpe_pkg::cfg_idx_t         cfg_index,
    input gpe_pkg::word_t            cfg_data
);

    // configuration
    gpe_pkg::word_t amp_reg;
    gpe_pkg::word_t cent_reg;
    gpe_pkg::wid_t  width_reg;

    // pipeline advance
    logic en;

    // stage: signed difference
    logic                       d_valid_reg;
    logic [gpe_pkg::DATA_W:0]   d_reg;
    logic [gpe_pkg::DATA_W:0]   d_next;

    // stage: magnitude, tail check, divider numerator
    logic                       n_valid_reg;
    logic                       far_reg;
    gpe_pkg::num_t              num_reg;
    logic [gpe_pkg::DATA_W:0]   ad;
    logic                       far_next;

    gpe_pkg::div_req_t          div1_req;
    gpe_pkg::div_stage_t        div1_rsp;
    gpe_pkg::exp_req_t          exp_req;
    gpe_pkg::sq_stage_t         exp_rsp;

    // stage: |amplitude| * E
    logic                       m_valid_reg;
    gpe_pkg::num_t              m_reg;
    gpe_pkg::num_t              m_next;
    gpe_pkg::e_t                e_big;
    gpe_pkg::word_t             amp_mag;

    // stage: partial products with 1/sqrt(pi)
    logic                       pp_valid_reg;
    gpe_pkg::pl_t               pl_reg;
    gpe_pkg::ph_t               ph_reg;

    // stage: scaled product in the divider's number range
    logic                       p_valid_reg;
    gpe_pkg::num_t              p_reg;
    gpe_pkg::p_t                p_full;

    gpe_pkg::div_req_t          div2_req;
    gpe_pkg::div_stage_t        div2_rsp;

    // output register
    logic                       out_valid_reg;
    gpe_pkg::word_t             out_value_reg;
    logic                       out_sat_reg;
    gpe_pkg::word_t             value_next;
    logic                       sat_next;

    // Register writes; an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg   <= gpe_pkg::AMP_RESET;
            cent_reg  <= gpe_pkg::CENT_RESET;
            width_reg <= gpe_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gpe_pkg::REG_AMPLITUDE: amp_reg   <= cfg_data;
                gpe_pkg::REG_CENTROID:  cent_reg  <= cfg_data;
                gpe_pkg::REG_WIDTH:     width_reg <= cfg_data[gpe_pkg::WIDTH_W-1:0];
                default:                ;
            endcase
        end
    end

    // Advance whenever the output slot is empty or is being taken this cycle.
    assign en            = !out_valid_reg || results.ready;
    assign samples.ready = en;

    // Difference x - centroid, exact in one extra bit.
    assign d_next = {samples.sample_pos[gpe_pkg::DATA_W-1], samples.sample_pos}
                    - {cent_reg[gpe_pkg::DATA_W-1], cent_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    // |d|, and the far tail |u| >= 8 seen as |d| >= 8 * width, which also
    // keeps the |u| quotient inside the divider's range.
    assign ad       = d_reg[gpe_pkg::DATA_W] ? (~d_reg + 1'b1) : d_reg;
    assign far_next = {1'b0, ad} >= {width_reg, {gpe_pkg::FAR_SHIFT{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            far_reg <= far_next;
            num_reg <= gpe_pkg::num_t'({ad, {gpe_pkg::FRAC_BITS{1'b0}}});
        end
    end

    // |u| in Q.F = floor(|d| * 2^F / width)
    always_comb
    begin
        div1_req.valid = n_valid_reg;
        div1_req.tag   = far_reg;
        div1_req.num   = num_reg;
    end

    gpe_div u_div_u (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .req     (div1_req),
        .divisor (width_reg),
        .rsp     (div1_rsp)
    );

    always_comb
    begin
        exp_req.valid = div1_rsp.valid;
        exp_req.far   = div1_rsp.tag;
        exp_req.a     = div1_rsp.quot[gpe_pkg::A_W-1:0];
    end

    gpe_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (exp_req),
        .rsp   (exp_rsp)
    );

    // Drop to Q.F, zero the far tail, scale by |amplitude|.
    assign e_big   = exp_rsp.far ? '0
                   : gpe_pkg::e_t'(exp_rsp.e >> (gpe_pkg::Q_FRAC - gpe_pkg::FRAC_BITS));
    assign amp_mag = amp_reg[gpe_pkg::DATA_W-1] ? (~amp_reg + 1'b1) : amp_reg;
    assign m_next  = gpe_pkg::num_t'(amp_mag) * gpe_pkg::num_t'(e_big);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg  <= 1'b0;
            pp_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg  <= exp_rsp.valid;
            pp_valid_reg <= m_valid_reg;
            p_valid_reg  <= pp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_reg <= '0;
        else if (en)
            m_reg <= m_next;
    end

    // m * K split into two products of at most 32 bits a side.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg <= gpe_pkg::pl_t'(m_reg[gpe_pkg::SPLIT_W-1:0])
                      * gpe_pkg::pl_t'(gpe_pkg::INV_SQRT_PI);
            ph_reg <= gpe_pkg::ph_t'(m_reg[gpe_pkg::NUM_W-1:gpe_pkg::SPLIT_W])
                      * gpe_pkg::ph_t'(gpe_pkg::INV_SQRT_PI);
        end
    end

    // floor(m*K / 2^30); dividing that by width gives the magnitude exactly.
    assign p_full = (gpe_pkg::p_t'(ph_reg) << gpe_pkg::SPLIT_W) + gpe_pkg::p_t'(pl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_full[gpe_pkg::Q_FRAC+gpe_pkg::NUM_W-1:gpe_pkg::Q_FRAC];
    end

    // Tag a quotient of 2^32 or more; it saturates in any case.
    always_comb
    begin
        div2_req.valid = p_valid_reg;
        div2_req.tag   = gpe_pkg::wid_t'(p_reg[gpe_pkg::NUM_W-1:gpe_pkg::QUOT_W])
                         >= width_reg;
        div2_req.num   = p_reg;
    end

    gpe_div u_div_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .req     (div2_req),
        .divisor (width_reg),
        .rsp     (div2_rsp)
    );

    // Apply the sign, clip to the Q16.16 range, or pass amplitude through
    // when width is zero.
    always_comb
    begin
        logic neg;
        logic big;
        neg = amp_reg[gpe_pkg::DATA_W-1];
        if (neg)
            big = div2_rsp.quot > gpe_pkg::SAT_NEG;
        else
            big = div2_rsp.quot > gpe_pkg::SAT_POS;
        if (width_reg == '0)
        begin
            value_next = amp_reg;
            sat_next   = 1'b0;
        end
        else if (div2_rsp.tag || big)
        begin
            value_next = neg ? gpe_pkg::SAT_NEG : gpe_pkg::SAT_POS;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = neg ? (~div2_rsp.quot + 1'b1) : div2_rsp.quot;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div2_rsp.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= value_next;
            out_sat_reg   <= sat_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.value     = out_value_reg;
    assign results.saturated = out_sat_reg;

    // A clipped result sits exactly at one of the two range limits.
    `GPE_ASSERT_SAME(a_sat_at_limit, results.valid && results.saturated, (results.value == gpe_pkg::SAT_POS) || (results.value == gpe_pkg::SAT_NEG), "saturated result not at a range limit")
    // A held result freezes the whole pipe, so no new sample may transfer.
    `GPE_ASSERT_SAME(a_stall_blocks_input, results.valid && !results.ready, !samples.ready, "sample taken while result is held")
    // The far tail must reach the scaler as a zero product.
    `GPE_ASSERT_NEXT(a_far_tail_zero, exp_rsp.valid && exp_rsp.far && en, m_reg == '0, "far tail gave nonzero product")

endmodule
